// ===== hw/rtl/ralu_pkg.sv =====
package ralu_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_INV = 3'd4,
		OP_NEG = 3'd5,
		OP_RED = 3'd6,
		OP_NOP = 3'd7
	} op_t;

	localparam int FIELD_W = 32;

endpackage

// ===== hw/rtl/rational_alu_with_reduce.sv =====
// sequencing: inverse, negate, no-op and equal-denominator add/sub go straight to the output;
// cross-multiplied add/sub use three multiplies, multiply and divide use two;
// reduce runs the gcd steps and then two divides, each on the serial divider
// throughput: one request at a time; the next is taken once the result register is free
// reset: arst_n asynchronously clears the sequencer and the result valid
module rational_alu_with_reduce #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] res_num,
	output logic signed [31:0] res_den,
	output logic        gcd_zero
);
	localparam int W  = DATA_WIDTH;
	localparam int FW = ralu_pkg::FIELD_W;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_M1   = 9'b000000010,
		ST_M2   = 9'b000000100,
		ST_M3   = 9'b000001000,
		ST_GCD  = 9'b000010000,
		ST_Q1   = 9'b000100000,
		ST_Q2   = 9'b001000000,
		ST_OUT  = 9'b010000000,
		ST_WAIT = 9'b100000000
	} state_t;

	state_t state_q;
	ralu_pkg::op_t op_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q, t1_q, t2_q, ga_q, gb_q;
	logic [W-1:0] rn_q, rd_q;
	logic         flag_q;
	logic         ovalid_q;

	logic         m_start, m_done, d_start, d_done;
	logic [W-1:0] mx, my, mp, dn, dd, dq, dr;

	function automatic logic [W-1:0] fin(input logic [FW-1:0] v);
		logic [63:0] e;
		e = {{(64 - FW){v[FW-1]}}, v};
		return e[W-1:0];
	endfunction

	function automatic logic [FW-1:0] fout(input logic [W-1:0] v);
		logic [63:0] e;
		e = {{(64 - W){v[W-1]}}, v};
		return e[FW-1:0];
	endfunction

	ralu_mul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(m_start), .x(mx), .y(my),
		.done(m_done), .p(mp)
	);

	ralu_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start), .n(dn), .d(dd),
		.done(d_done), .quo(dq), .rem(dr)
	);

	logic accept;
	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	assign accept   = in_valid && !in_stall;

	logic go_q;

	// operand selection for the shared multiplier and divider
	always_comb begin
		mx = an_q;
		my = bd_q;
		unique case (state_q)
			ST_M2: begin
				if (op_q == ralu_pkg::OP_MUL) begin
					mx = ad_q; my = bd_q;
				end else if (op_q == ralu_pkg::OP_DIV) begin
					mx = ad_q; my = bn_q;
				end else begin
					mx = bn_q; my = ad_q;
				end
			end
			ST_M3: begin
				mx = ad_q; my = bd_q;
			end
			default: begin
				if (op_q == ralu_pkg::OP_MUL) begin
					mx = an_q; my = bn_q;
				end else begin
					mx = an_q; my = bd_q;
				end
			end
		endcase
	end

	always_comb begin
		dn = ga_q;
		dd = gb_q;
		unique case (state_q)
			ST_Q1:   begin dn = an_q; dd = ga_q; end
			ST_Q2:   begin dn = ad_q; dd = ga_q; end
			default: begin dn = ga_q; dd = gb_q; end
		endcase
	end

	assign m_start = go_q && (state_q == ST_M1 || state_q == ST_M2 || state_q == ST_M3);
	assign d_start = go_q && ((state_q == ST_GCD && gb_q != '0) ||
		state_q == ST_Q1 || state_q == ST_Q2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			go_q     <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (ralu_pkg::op_t'(req_type))
							ralu_pkg::OP_ADD, ralu_pkg::OP_SUB: begin
								if (fin(a_den) == fin(b_den)) state_q <= ST_OUT;
								else begin
									state_q <= ST_M1; go_q <= 1'b1;
								end
							end
							ralu_pkg::OP_MUL, ralu_pkg::OP_DIV: begin
								state_q <= ST_M1; go_q <= 1'b1;
							end
							ralu_pkg::OP_RED: begin
								state_q <= ST_GCD; go_q <= 1'b1;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_M1: if (m_done) begin
					state_q <= ST_M2; go_q <= 1'b1;
				end
				ST_M2: if (m_done) begin
					if (op_q == ralu_pkg::OP_ADD || op_q == ralu_pkg::OP_SUB) begin
						state_q <= ST_M3; go_q <= 1'b1;
					end else state_q <= ST_OUT;
				end
				ST_M3: if (m_done) state_q <= ST_OUT;
				ST_GCD: begin
					if (gb_q == '0 && !go_q) begin
						if (ga_q == '0) state_q <= ST_OUT;
						else begin
							state_q <= ST_Q1; go_q <= 1'b1;
						end
					end else if (d_done) go_q <= 1'b1;
				end
				ST_Q1: if (d_done) begin
					state_q <= ST_Q2; go_q <= 1'b1;
				end
				ST_Q2: if (d_done) state_q <= ST_OUT;
				ST_OUT: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!ovalid_q || !out_stall) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// gcd start guard: when b is already zero no divide is issued
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= ralu_pkg::op_t'(req_type);
			an_q   <= fin(a_num);
			ad_q   <= fin(a_den);
			bn_q   <= fin(b_num);
			bd_q   <= fin(b_den);
			ga_q   <= fin(a_num);
			gb_q   <= fin(a_den);
			rn_q   <= fin(a_num);
			rd_q   <= fin(a_den);
			flag_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_M1: if (m_done) t1_q <= mp;
				ST_M2: if (m_done) begin
					if (op_q == ralu_pkg::OP_MUL || op_q == ralu_pkg::OP_DIV) begin
						rn_q <= t1_q; rd_q <= mp;
					end else t2_q <= mp;
				end
				ST_M3: if (m_done) begin
					rd_q <= mp;
					rn_q <= (op_q == ralu_pkg::OP_ADD) ? t1_q + t2_q : t1_q - t2_q;
				end
				ST_GCD: begin
					if (d_done) begin
						ga_q <= gb_q; gb_q <= dr;
					end
					if (gb_q == '0 && ga_q == '0 && !go_q) flag_q <= 1'b1;
				end
				ST_Q1: if (d_done) rn_q <= dq;
				ST_Q2: if (d_done) rd_q <= dq;
				ST_OUT: begin
					unique case (op_q)
						ralu_pkg::OP_ADD: if (ad_q == bd_q) rn_q <= an_q + bn_q;
						ralu_pkg::OP_SUB: if (ad_q == bd_q) rn_q <= an_q - bn_q;
						ralu_pkg::OP_INV: begin rn_q <= ad_q; rd_q <= an_q; end
						ralu_pkg::OP_NEG: rn_q <= -an_q;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && (!ovalid_q || !out_stall)) begin
			res_num  <= fout(rn_q);
			res_den  <= fout(rd_q);
			gcd_zero <= flag_q;
		end
	end

	assign out_valid = ovalid_q;
endmodule

// ===== hw/rtl/ralu_mul.sv =====
// bit-serial shift-add multiplier, product wraps at the data width
module ralu_mul #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	output logic         done,
	output logic [W-1:0] p
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  mcand_q;
	logic [W-1:0]  mplier_q;
	logic [W-1:0]  acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= x;
			mplier_q <= y;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[W-1:1]};
		end
	end

	assign p = acc_q;
endmodule

// ===== hw/rtl/ralu_div.sv =====
// restoring divider on magnitudes, one quotient bit per cycle, truncating signs
module ralu_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] n,
	input  logic [W-1:0] d,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  dm_q;
	logic          nneg_q;
	logic          qneg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted = {r_q, q_q[W-1]};
	assign trial   = shifted - {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= n[W-1] ? -n : n;
			dm_q   <= d[W-1] ? -d : d;
			r_q    <= '0;
			nneg_q <= n[W-1];
			qneg_q <= n[W-1] ^ d[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= shifted[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo = qneg_q ? -q_q : q_q;
	assign rem = nneg_q ? -r_q : r_q;
endmodule

// ===== sim/rational_alu_checker.sv =====
module rational_alu_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] res_num,
	input  logic signed [31:0] res_den,
	input  logic               gcd_zero,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] num;
		logic signed [31:0] den;
		logic               flag;
	} frac_res_t;

	frac_res_t expected_fracs[$];

	function automatic logic signed [31:0] trunc_rem(logic signed [31:0] x,
			logic signed [31:0] y);
		longint mx, my, r;
		mx = (x < 0) ? -longint'(x) : longint'(x);
		my = (y < 0) ? -longint'(y) : longint'(y);
		r = mx % my;
		if (x < 0) r = -r;
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] trunc_quo(logic signed [31:0] x,
			logic signed [31:0] y);
		longint mx, my, q;
		mx = (x < 0) ? -longint'(x) : longint'(x);
		my = (y < 0) ? -longint'(y) : longint'(y);
		q = mx / my;
		if ((x < 0) != (y < 0)) q = -q;
		return q[31:0];
	endfunction

	function automatic frac_res_t compute_frac(logic [2:0] op, logic signed [31:0] an,
			logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
		frac_res_t r;
		logic signed [31:0] g, x, t;
		r.num = an;
		r.den = ad;
		r.flag = 1'b0;
		case (ralu_pkg::op_t'(op))
			ralu_pkg::OP_ADD, ralu_pkg::OP_SUB: begin
				if (ad == bd) begin
					r.num = (op == ralu_pkg::OP_ADD) ? an + bn : an - bn;
				end else begin
					r.num = (op == ralu_pkg::OP_ADD) ? an * bd + bn * ad : an * bd - bn * ad;
					r.den = ad * bd;
				end
			end
			ralu_pkg::OP_MUL: begin
				r.num = an * bn;
				r.den = ad * bd;
			end
			ralu_pkg::OP_DIV: begin
				r.num = an * bd;
				r.den = ad * bn;
			end
			ralu_pkg::OP_INV: begin
				r.num = ad;
				r.den = an;
			end
			ralu_pkg::OP_NEG: r.num = -an;
			ralu_pkg::OP_RED: begin
				x = an;
				g = ad;
				while (g != 0) begin
					t = g;
					g = trunc_rem(x, g);
					x = t;
				end
				if (x == 0) begin
					r.flag = 1'b1;
				end else begin
					r.num = trunc_quo(an, x);
					r.den = trunc_quo(ad, x);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	assign pending = expected_fracs.size();

	always @(posedge clk or negedge arst_n) begin
		frac_res_t e;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_fracs.push_back(compute_frac(req_type, a_num, a_den, b_num, b_den));
			if (out_valid && !out_stall) begin
				if (expected_fracs.size() == 0) begin
					if (errors < 10)
						$display("unexpected result %0d/%0d flag %0b", res_num, res_den,
							gcd_zero);
					errors <= errors + 1;
				end else begin
					e = expected_fracs.pop_front();
					if (e.num !== res_num || e.den !== res_den || e.flag !== gcd_zero) begin
						if (errors < 10)
							$display("mismatch: expected %0d/%0d flag %0b, got %0d/%0d flag %0b",
								e.num, e.den, e.flag, res_num, res_den, gcd_zero);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== sim/tb_rational_alu_with_reduce.sv =====
module tb_rational_alu_with_reduce;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         req_type;
	logic signed [31:0] a_num, a_den, b_num, b_den;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] res_num, res_den;
	logic               gcd_zero;
	int                 errors;
	int                 pending;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	longint             cycles;

	localparam logic signed [31:0] MAXV = 32'sh7fffffff;
	localparam logic signed [31:0] MINV = 32'sh80000000;

	rational_alu_with_reduce dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .gcd_zero(gcd_zero)
	);

	rational_alu_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .gcd_zero(gcd_zero),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 4000000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_request(logic [2:0] op, logic signed [31:0] an,
			logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $signed($urandom_range(40)) - 20;
			2: return $signed($urandom_range(2000)) * ($urandom_range(1) ? 1 : -1);
			3: begin
				case ($urandom_range(4))
					0: return MAXV;
					1: return MINV;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: return $signed($urandom_range(100000)) - 50000;
		endcase
	endfunction

	task automatic random_requests(int count);
		logic signed [31:0] an, ad, bn, bd, k;
		logic [2:0] op;
		for (int i = 0; i < count; i++) begin
			op = 3'($urandom_range(7));
			an = pick_value();
			ad = pick_value();
			bn = pick_value();
			bd = ($urandom_range(2) == 0) ? ad : pick_value();
			if (op == ralu_pkg::OP_RED && $urandom_range(1)) begin
				k = $signed($urandom_range(60)) - 30;
				an = an % 1000 * k;
				ad = ad % 1000 * k;
			end
			send_request(op, an, ad, bn, bd);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = ralu_pkg::OP_ADD;
		a_num = 0;
		a_den = 0;
		b_num = 0;
		b_den = 0;
		send_idle_pct = 30;
		recv_stall_pct = 61;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_request(ralu_pkg::OP_ADD, 1, 3, 2, 3);
		send_request(ralu_pkg::OP_ADD, 1, 2, 1, 3);
		send_request(ralu_pkg::OP_SUB, 5, 7, 9, 7);
		send_request(ralu_pkg::OP_SUB, MAXV, 3, MINV, -5);
		send_request(ralu_pkg::OP_MUL, MAXV, MINV, MAXV, MINV);
		send_request(ralu_pkg::OP_MUL, -1, -1, MINV, MAXV);
		send_request(ralu_pkg::OP_DIV, 3, 4, 0, 5);
		send_request(ralu_pkg::OP_DIV, MINV, MAXV, -1, 2);
		send_request(ralu_pkg::OP_INV, 0, 7, 1, 1);
		send_request(ralu_pkg::OP_INV, MINV, MAXV, 0, 0);
		send_request(ralu_pkg::OP_NEG, MINV, 1, 0, 0);
		send_request(ralu_pkg::OP_NEG, MAXV, -1, -1, -1);
		send_request(ralu_pkg::OP_RED, 0, 0, 0, 0);
		send_request(ralu_pkg::OP_RED, 12, 0, 0, 0);
		send_request(ralu_pkg::OP_RED, 0, -8, 0, 0);
		send_request(ralu_pkg::OP_RED, 12, -18, 0, 0);
		send_request(ralu_pkg::OP_RED, MINV, -1, 0, 0);
		send_request(ralu_pkg::OP_RED, MINV, MINV, 0, 0);
		send_request(ralu_pkg::OP_RED, 1836311903, 1134903170, 0, 0);
		send_request(ralu_pkg::OP_RED, MAXV, MINV, 0, 0);
		send_request(ralu_pkg::OP_NOP, 123, -456, 7, 8);
		send_request(ralu_pkg::OP_NOP, MINV, MAXV, -1, -1);

		random_requests(125);
		send_idle_pct = 61;
		recv_stall_pct = 30;
		random_requests(125);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_requests(120);
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (1700) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
